FILE: hw/rtl/nrpi_pkg.sv
// shared types and constants for the nearest ramp palette index block
package nrpi_pkg;

	localparam int PALETTE_ENTRIES_DEF = 256;
	localparam int RAMP_STEPS_DEF      = 85;
	localparam int COMP_W              = 8;
	localparam int INDEX_W             = 8;
	localparam int SQ_W                = 2 * COMP_W;
	localparam int DIST_W              = SQ_W + 2;
	localparam int COMP_MAX            = 255;

	typedef struct packed {
		logic [COMP_W-1:0] red;
		logic [COMP_W-1:0] green;
		logic [COMP_W-1:0] blue;
	} rgb_t;

endpackage

FILE: hw/rtl/nrpi_palette_rom.sv
// palette memory holding the red, green and blue ramps, one registered read port
module nrpi_palette_rom #(
	parameter int PALETTE_ENTRIES = nrpi_pkg::PALETTE_ENTRIES_DEF,
	parameter int RAMP_STEPS      = nrpi_pkg::RAMP_STEPS_DEF,
	parameter int ADDR_W          = (PALETTE_ENTRIES > 2) ? $clog2(PALETTE_ENTRIES) : 1
) (
	input  logic              clk,
	input  logic [ADDR_W-1:0] addr,
	output nrpi_pkg::rgb_t    data
);

	nrpi_pkg::rgb_t rom_w [PALETTE_ENTRIES];

	for (genvar p = 0; p < PALETTE_ENTRIES; p++) begin : g_entry
		localparam int K = (p <= RAMP_STEPS) ? p :
			(p <= 2 * RAMP_STEPS) ? p - RAMP_STEPS : p - 2 * RAMP_STEPS;
		localparam int VAL = (p >= 1 && p <= 3 * RAMP_STEPS) ?
			((RAMP_STEPS + 1 - K) * nrpi_pkg::COMP_MAX) / RAMP_STEPS : 0;
		localparam logic [nrpi_pkg::COMP_W-1:0] V = nrpi_pkg::COMP_W'(VAL);
		localparam bit IS_RED   = (p >= 1) && (p <= RAMP_STEPS);
		localparam bit IS_GREEN = (p > RAMP_STEPS) && (p <= 2 * RAMP_STEPS);
		localparam bit IS_BLUE  = (p > 2 * RAMP_STEPS) && (p <= 3 * RAMP_STEPS);

		assign rom_w[p].red   = IS_RED   ? V : '0;
		assign rom_w[p].green = IS_GREEN ? V : '0;
		assign rom_w[p].blue  = IS_BLUE  ? V : '0;
	end

	always_ff @(posedge clk) begin
		data <= rom_w[addr];
	end

endmodule

FILE: hw/rtl/nearest_ramp_palette_index.sv
// top level: nearest palette entry search over the ramp palette
// Each pixel item is compared against palette entries 1 to PALETTE_ENTRIES-1, one entry per
// cycle from the single read port of the palette memory; after the scan, the last entries
// pass through the registered memory read and the registered distance stage before the
// result is loaded into the output register. No new item is taken until the search for the
// previous one is over. The distance is the squared Euclidean distance over the three
// components and ties go to the lowest index.
// A new item is accepted once the previous result has left the search, even while that
// result still waits in the output register; the palette is fixed, so no clearing pass
// follows reset.
module nearest_ramp_palette_index #(
	parameter int PALETTE_ENTRIES = nrpi_pkg::PALETTE_ENTRIES_DEF,
	parameter int RAMP_STEPS      = nrpi_pkg::RAMP_STEPS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [nrpi_pkg::COMP_W-1:0]  pixel_red,
	input  logic [nrpi_pkg::COMP_W-1:0]  pixel_green,
	input  logic [nrpi_pkg::COMP_W-1:0]  pixel_blue,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [nrpi_pkg::INDEX_W-1:0] palette_index
);

	localparam int ADDR_W = (PALETTE_ENTRIES > 2) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PALETTE_ENTRIES - 1);
	localparam logic [ADDR_W-1:0] FIRST_ADDR = ADDR_W'(1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_HOLD  = 4'b1000
	} state_t;

	state_t state_q;

	logic [ADDR_W-1:0] addr_q;
	nrpi_pkg::rgb_t    pix_q;
	nrpi_pkg::rgb_t    rd_data;

	logic              vld_s1, last_s1, first_s1;
	logic [ADDR_W-1:0] idx_s1;

	logic                      vld_s2, last_s2, first_s2;
	logic [ADDR_W-1:0]         idx_s2;
	logic [nrpi_pkg::SQ_W-1:0] sq_r_s2, sq_g_s2, sq_b_s2;

	logic [nrpi_pkg::DIST_W-1:0] best_dist_q;
	logic [ADDR_W-1:0]           best_idx_q;
	logic                        out_valid_q;
	logic [nrpi_pkg::INDEX_W-1:0] out_index_q;

	logic [nrpi_pkg::DIST_W-1:0] dist_sum;
	logic                        take_new;
	logic [ADDR_W-1:0]           final_idx;
	logic                        finish;
	logic                        out_free;
	logic                        accept;

	nrpi_palette_rom #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES),
		.RAMP_STEPS     (RAMP_STEPS),
		.ADDR_W         (ADDR_W)
	) u_rom (
		.clk (clk),
		.addr(addr_q),
		.data(rd_data)
	);

	function automatic logic [nrpi_pkg::SQ_W-1:0] sq_diff(
		input logic [nrpi_pkg::COMP_W-1:0] a,
		input logic [nrpi_pkg::COMP_W-1:0] b
	);
		logic [nrpi_pkg::COMP_W-1:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return nrpi_pkg::SQ_W'(d) * nrpi_pkg::SQ_W'(d);
	endfunction

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign dist_sum = nrpi_pkg::DIST_W'(sq_r_s2) + nrpi_pkg::DIST_W'(sq_g_s2)
		+ nrpi_pkg::DIST_W'(sq_b_s2);
	assign take_new  = first_s2 || (dist_sum < best_dist_q);
	assign final_idx = take_new ? idx_s2 : best_idx_q;
	assign finish    = vld_s2 && last_s2;

	// scan sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q  <= FIRST_ADDR;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						addr_q  <= FIRST_ADDR;
					end
				end
				ST_SCAN: begin
					if (addr_q == LAST_ADDR) begin
						state_q <= ST_DRAIN;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (finish) begin
						state_q <= out_free ? ST_IDLE : ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q.red   <= pixel_red;
			pix_q.green <= pixel_green;
			pix_q.blue  <= pixel_blue;
		end
	end

	// read and distance pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_SCAN);
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= addr_q;
		last_s1  <= (addr_q == LAST_ADDR);
		first_s1 <= (addr_q == FIRST_ADDR);

		idx_s2   <= idx_s1;
		last_s2  <= last_s1;
		first_s2 <= first_s1;
		sq_r_s2  <= sq_diff(pix_q.red, rd_data.red);
		sq_g_s2  <= sq_diff(pix_q.green, rd_data.green);
		sq_b_s2  <= sq_diff(pix_q.blue, rd_data.blue);

		if (vld_s2 && take_new) begin
			best_dist_q <= dist_sum;
			best_idx_q  <= idx_s2;
		end
	end

	// output register, loaded straight from the compare or from the held best
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DRAIN && finish) || state_q == ST_HOLD) begin
			if (out_free) begin
				out_valid_q <= 1'b1;
			end
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == ST_DRAIN && finish) begin
				out_index_q <= nrpi_pkg::INDEX_W'(final_idx);
			end else if (state_q == ST_HOLD) begin
				out_index_q <= nrpi_pkg::INDEX_W'(best_idx_q);
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign palette_index = out_index_q;

endmodule
